// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/eot_pkg.sv
// ---------------------------------------------------------------------------
// eot_pkg
// Types, field numbers, status codes and layout tables for the EOT header
// parser.
// ---------------------------------------------------------------------------
package eot_pkg;

    // Field numbers in layout order
    localparam logic [5:0] FLD_NONE        = 6'd0;
    localparam logic [5:0] FLD_EOT_SIZE    = 6'd1;
    localparam logic [5:0] FLD_VERSION     = 6'd3;
    localparam logic [5:0] FLD_PANOSE      = 6'd5;
    localparam logic [5:0] FLD_MAGIC       = 6'd10;
    localparam logic [5:0] FLD_FULL_NAME   = 6'd33;
    localparam logic [5:0] FLD_PADDING5    = 6'd34;
    localparam logic [5:0] FLD_ROOT_STRING = 6'd36;
    localparam logic [5:0] FLD_ROOT_CHECK  = 6'd37;
    localparam logic [5:0] FLD_LAST        = 6'd44;

    localparam logic [31:0] PANOSE_LEN  = 32'd10;
    localparam logic [31:0] MAGIC_WORD  = 32'h0000_504C;
    localparam logic [31:0] VERSION_1   = 32'h0001_0000;
    localparam logic [31:0] VERSION_2_1 = 32'h0002_0001;
    localparam logic [31:0] VERSION_2_2 = 32'h0002_0002;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_NONZERO   = 3'd3,
        ST_BAD_VER   = 3'd4,
        ST_TRUNC     = 3'd5
    } status_t;

    typedef struct packed {
        logic [5:0]  phase;
        logic [31:0] bif;
        logic [31:0] accum;
        logic [31:0] len;
        logic [31:0] version;
        status_t     status;
    } eot_state_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  field_id;
        logic [31:0] value;
        logic [31:0] index;
    } eot_result_t;

    localparam eot_state_t STATE_RESET = '{
        phase:   FLD_EOT_SIZE,
        bif:     32'd0,
        accum:   32'd0,
        len:     32'd0,
        version: 32'd0,
        status:  ST_BUSY
    };

    // Bytes per scalar field; zero marks a byte-stream field
    function automatic logic [2:0] fld_bytes(input logic [5:0] id);
        logic [2:0] n;
        unique case (id)
            6'd1, 6'd2, 6'd3, 6'd4, 6'd8, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
            6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd37, 6'd38, 6'd42,
            6'd43:
                n = 3'd4;
            6'd6, 6'd7:
                n = 3'd1;
            6'd9, 6'd10, 6'd22, 6'd23, 6'd25, 6'd26, 6'd28, 6'd29, 6'd31,
            6'd32, 6'd34, 6'd35, 6'd39, 6'd40:
                n = 3'd2;
            default:
                n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic must_be_zero(input logic [5:0] id);
        return (id >= 6'd18 && id <= 6'd22) || id == 6'd25 || id == 6'd28 ||
               id == 6'd31 || id == 6'd34 || id == 6'd39;
    endfunction

    function automatic logic is_size_field(input logic [5:0] id);
        return id == 6'd23 || id == 6'd26 || id == 6'd29 || id == 6'd32 ||
               id == 6'd35 || id == 6'd40 || id == 6'd43;
    endfunction

endpackage

// File: hdl/eot_step.sv
// ---------------------------------------------------------------------------
// eot_step
// Next-state and result logic for one byte transfer: field assembly,
// checks and layout advance, including the skip over an empty byte field.
// ---------------------------------------------------------------------------
module eot_step (
    input  eot_pkg::eot_state_t  cur,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_data,
    input  logic                 frame_start,
    output eot_pkg::eot_state_t  nxt,
    output eot_pkg::eot_result_t res
);
    import eot_pkg::*;

    typedef struct packed {
        logic [5:0] phase;
        logic       stop;
        status_t    code;
    } adv_t;

    // One step of the layout walk from a finished field
    function automatic adv_t adv_one(input logic [5:0] from, input logic [31:0] ver);
        adv_t a;
        a.phase = FLD_NONE;
        a.stop  = 1'b0;
        a.code  = ST_BUSY;
        if (from == FLD_FULL_NAME) begin
            if (ver == VERSION_1) begin
                a.stop = 1'b1;
                a.code = ST_OK;
            end else if (ver != VERSION_2_1 && ver != VERSION_2_2) begin
                a.stop = 1'b1;
                a.code = ST_BAD_VER;
            end else begin
                a.phase = FLD_PADDING5;
            end
        end else if (from == FLD_ROOT_STRING) begin
            if (ver == VERSION_2_1) begin
                a.stop = 1'b1;
                a.code = ST_OK;
            end else begin
                a.phase = FLD_ROOT_CHECK;
            end
        end else if (from >= FLD_LAST) begin
            a.stop = 1'b1;
            a.code = ST_OK;
        end else begin
            a.phase = from + 6'd1;
        end
        return a;
    endfunction

    eot_state_t  base;
    logic [2:0]  sz;
    logic [31:0] bif_inc;
    logic [31:0] placed;
    logic [31:0] acc;
    logic [31:0] len_new;
    logic [31:0] ver_new;
    logic        do_adv;
    adv_t        a1;
    adv_t        a2;

    // Restart at offset zero on frame start
    assign base    = frame_start ? STATE_RESET : cur;
    assign sz      = fld_bytes(base.phase);
    assign bif_inc = base.bif + 32'd1;
    assign placed  = {24'd0, data_byte} << {base.bif[1:0], 3'b000};
    assign acc     = base.accum | placed;
    assign ver_new = (sz != 3'd0 && base.phase == FLD_VERSION) ? acc : base.version;
    assign len_new = (sz != 3'd0 && is_size_field(base.phase)) ? acc : base.len;
    assign a1      = adv_one(base.phase, ver_new);
    assign a2      = adv_one(a1.phase, ver_new);

    always_comb
    begin
        nxt            = base;
        res.status     = ST_BUSY;
        res.field_id   = FLD_NONE;
        res.value      = 32'd0;
        res.index      = 32'd0;
        do_adv         = 1'b0;

        if (end_of_data)
        begin
            // Stream ended: truncation if still busy, no byte consumed
            if (base.status == ST_BUSY)
            begin
                nxt.status = ST_TRUNC;
                nxt.phase  = FLD_NONE;
            end
        end
        else if (base.status == ST_BUSY && base.phase != FLD_NONE &&
                 base.phase <= FLD_LAST)
        begin
            nxt.bif = bif_inc;
            if (sz == 3'd0)
            begin
                // Pass a data byte with its index
                res.field_id = base.phase;
                res.value    = {24'd0, data_byte};
                res.index    = base.bif;
                do_adv       = (bif_inc >= base.len);
            end
            else
            begin
                // Assemble a little-endian scalar
                nxt.accum = acc;
                if (bif_inc >= {29'd0, sz})
                begin
                    res.field_id = base.phase;
                    res.value    = acc;
                    nxt.version  = ver_new;
                    nxt.len      = len_new;
                    if (base.phase == FLD_MAGIC && acc != MAGIC_WORD)
                    begin
                        nxt.status = ST_BAD_MAGIC;
                        nxt.phase  = FLD_NONE;
                    end
                    else if (must_be_zero(base.phase) && acc != 32'd0)
                    begin
                        nxt.status = ST_NONZERO;
                        nxt.phase  = FLD_NONE;
                    end
                    else
                    begin
                        do_adv = 1'b1;
                    end
                end
            end
        end

        // Advance the layout, skipping an empty byte field once
        if (do_adv)
        begin
            if (a1.stop)
            begin
                nxt.status = a1.code;
                nxt.phase  = FLD_NONE;
            end
            else
            begin
                nxt.phase = a1.phase;
                nxt.bif   = 32'd0;
                nxt.accum = 32'd0;
                if (a1.phase == FLD_PANOSE)
                    nxt.len = PANOSE_LEN;
                if (fld_bytes(a1.phase) == 3'd0 && a1.phase != FLD_PANOSE &&
                    nxt.len == 32'd0)
                begin
                    if (a2.stop)
                    begin
                        nxt.status = a2.code;
                        nxt.phase  = FLD_NONE;
                    end
                    else
                    begin
                        nxt.phase = a2.phase;
                    end
                end
            end
        end

        res.status = nxt.status;
    end

endmodule

// File: hdl/eot_header_parser_top.sv
// A result is registered: the output register loads it on its input transfer.
// Throughput: one byte per cycle while the output is not stalled; the parser state and result register update together.
// Input ready follows the output register: free, or being drained in the same cycle.
// Reset (rst_n low, asynchronous): parser at offset zero, status busy, output empty.
// ---------------------------------------------------------------------------
// eot_header_parser_top
// Embedded OpenType header parser: one file byte per transfer, one result
// per transfer with field number, value, byte index and sticky status.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eot_header_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  parse_status,
    output logic [5:0]  field_id,
    output logic [31:0] field_value,
    output logic [31:0] byte_index
);
    import eot_pkg::*;

    eot_state_t  state_reg;
    eot_state_t  state_next;
    eot_result_t result_reg;
    eot_result_t result_next;
    logic        out_valid_reg;
    logic        in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    eot_step u_step (
        .cur         (state_reg),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .frame_start (frame_start),
        .nxt         (state_next),
        .res         (result_next)
    );

    // Advance parser state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (in_xfer)
            state_reg <= state_next;
    end

    // Hold output valid until the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign parse_status = result_reg.status;
    assign field_id     = result_reg.field_id;
    assign field_value  = result_reg.value;
    assign byte_index   = result_reg.index;

    // Checks
    `ASSERT_NOW(a_busy_phase, state_reg.status == ST_BUSY,
        state_reg.phase != FLD_NONE && state_reg.phase <= FLD_LAST,
        "busy parser outside the header layout")
    `ASSERT_NOW(a_stop_phase, state_reg.status != ST_BUSY,
        state_reg.phase == FLD_NONE, "stopped parser kept a layout phase")
    `ASSERT_NEXT(a_sticky, in_xfer && !frame_start && state_reg.status != ST_BUSY,
        parse_status == $past(state_reg.status), "final status not sticky")
    `ASSERT_NOW(a_field_range, out_valid_reg, field_id <= FLD_LAST,
        "field number beyond the layout")

endmodule
